/* src/mshd_pkg.sv */
// Package with the types, tables and constants shared by the heading block.
`timescale 1ns / 1ps
package mshd_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_LEN = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  localparam logic [0:0] REG_GAIN_SELECT = 1'b0;
  localparam logic [0:0] REG_DECLINATION = 1'b1;

  localparam logic [2:0] GAIN_INVALID = 3'd7;
  localparam logic signed [14:0] DECL_LIMIT = 15'sd11520;
  localparam logic [14:0] DECL_RESET = 15'd3374;
  localparam logic signed [16:0] HEADING_FULL = 17'sd23040;
  localparam logic signed [15:0] ANGLE_HALF = 16'sd11520;
  localparam logic signed [26:0] Z_HALF = 27'sd11796480;
  localparam logic signed [26:0] Z_FULL = 27'sd23592960;
  localparam logic signed [26:0] Z_ROUND = 27'sd512;
  localparam logic [27:0] SCALE_MUL = 28'd1600;
  localparam logic [63:0] RCP_NUM = 64'd4294967296;

  localparam logic [21:0] ATAN_TAB [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef struct packed {
    logic [2:0]         gain_select;
    logic signed [14:0] declination;
  } cfg_t;

  typedef struct packed {
    logic [25:0]        mag_x;
    logic [25:0]        mag_y;
    logic [25:0]        mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic [10:0]        lsb_xy;
    logic [10:0]        lsb_z;
    logic [24:0]        rcp_xy;
    logic [24:0]        rcp_z;
    logic               on_axis;
    logic signed [15:0] axis_angle;
    logic signed [26:0] cx;
    logic signed [26:0] cy;
    logic signed [26:0] cz;
    logic signed [14:0] decl;
  } front_t;

  typedef struct packed {
    front_t      f;
    logic [49:0] prod_x;
    logic [49:0] prod_y;
    logic [49:0] prod_z;
    logic [17:0] qe_x;
    logic [17:0] qe_y;
    logic [17:0] qe_z;
    logic [25:0] rem_x;
    logic [25:0] rem_y;
    logic [25:0] rem_z;
    logic signed [18:0] fld_x;
    logic signed [18:0] fld_y;
    logic signed [18:0] fld_z;
  } stage_t;

  typedef struct packed {
    logic signed [18:0] field_x;
    logic signed [18:0] field_y;
    logic signed [18:0] field_z;
    logic [14:0]        heading;
  } result_t;

  function automatic logic [10:0] lsb_xy_of(input logic [2:0] g);
    logic [10:0] v;
    case (g)
      3'd1: v = 11'd855;
      3'd2: v = 11'd670;
      3'd3: v = 11'd450;
      3'd4: v = 11'd400;
      3'd5: v = 11'd330;
      3'd6: v = 11'd230;
      default: v = 11'd1100;
    endcase
    return v;
  endfunction

  function automatic logic [10:0] lsb_z_of(input logic [2:0] g);
    logic [10:0] v;
    case (g)
      3'd1: v = 11'd760;
      3'd2: v = 11'd600;
      3'd3: v = 11'd400;
      3'd4: v = 11'd255;
      3'd5: v = 11'd295;
      3'd6: v = 11'd205;
      default: v = 11'd980;
    endcase
    return v;
  endfunction

  function automatic logic [24:0] rcp_xy_of(input logic [2:0] g);
    logic [63:0] v;
    case (g)
      3'd1: v = RCP_NUM / 64'd855;
      3'd2: v = RCP_NUM / 64'd670;
      3'd3: v = RCP_NUM / 64'd450;
      3'd4: v = RCP_NUM / 64'd400;
      3'd5: v = RCP_NUM / 64'd330;
      3'd6: v = RCP_NUM / 64'd230;
      default: v = RCP_NUM / 64'd1100;
    endcase
    return v[24:0];
  endfunction

  function automatic logic [24:0] rcp_z_of(input logic [2:0] g);
    logic [63:0] v;
    case (g)
      3'd1: v = RCP_NUM / 64'd760;
      3'd2: v = RCP_NUM / 64'd600;
      3'd3: v = RCP_NUM / 64'd400;
      3'd4: v = RCP_NUM / 64'd255;
      3'd5: v = RCP_NUM / 64'd295;
      3'd6: v = RCP_NUM / 64'd205;
      default: v = RCP_NUM / 64'd980;
    endcase
    return v[24:0];
  endfunction

endpackage

/* src/mshd_front.sv */
// Front end: forms the raw axes, picks the gain constants and prepares the CORDIC start vector.
`timescale 1ns / 1ps
module mshd_front (
  input  logic [7:0]       x_high,
  input  logic [7:0]       x_low,
  input  logic [7:0]       z_high,
  input  logic [7:0]       z_low,
  input  logic [7:0]       y_high,
  input  logic [7:0]       y_low,
  input  mshd_pkg::cfg_t   cfg,
  output mshd_pkg::front_t item
);

  logic signed [15:0] raw_x, raw_y, raw_z;
  logic [16:0] abs_x, abs_y, abs_z;
  logic [27:0] prod_x, prod_y, prod_z;
  logic signed [26:0] sx, sy;

  assign raw_x = $signed({x_high, x_low});
  assign raw_y = $signed({y_high, y_low});
  assign raw_z = $signed({z_high, z_low});

  assign abs_x = raw_x[15] ? 17'(-{raw_x[15], raw_x}) : {1'b0, raw_x};
  assign abs_y = raw_y[15] ? 17'(-{raw_y[15], raw_y}) : {1'b0, raw_y};
  assign abs_z = raw_z[15] ? 17'(-{raw_z[15], raw_z}) : {1'b0, raw_z};

  assign prod_x = {11'b0, abs_x} * mshd_pkg::SCALE_MUL;
  assign prod_y = {11'b0, abs_y} * mshd_pkg::SCALE_MUL;
  assign prod_z = {11'b0, abs_z} * mshd_pkg::SCALE_MUL;

  assign sx = $signed({{3{raw_x[15]}}, raw_x, 8'b0});
  assign sy = $signed({{3{raw_y[15]}}, raw_y, 8'b0});

  always_comb begin
    item.mag_x = prod_x[25:0];
    item.mag_y = prod_y[25:0];
    item.mag_z = prod_z[25:0];
    item.neg_x = raw_x[15];
    item.neg_y = raw_y[15];
    item.neg_z = raw_z[15];
    item.lsb_xy = mshd_pkg::lsb_xy_of(cfg.gain_select);
    item.lsb_z = mshd_pkg::lsb_z_of(cfg.gain_select);
    item.rcp_xy = mshd_pkg::rcp_xy_of(cfg.gain_select);
    item.rcp_z = mshd_pkg::rcp_z_of(cfg.gain_select);
    item.on_axis = (raw_y == 16'sd0);
    item.axis_angle = raw_x[15] ? mshd_pkg::ANGLE_HALF : 16'sd0;
    if (raw_x[15]) begin
      item.cx = -sx;
      item.cy = -sy;
      item.cz = mshd_pkg::Z_HALF;
    end else begin
      item.cx = sx;
      item.cy = sy;
      item.cz = 27'sd0;
    end
    if (cfg.declination > mshd_pkg::DECL_LIMIT) begin
      item.decl = mshd_pkg::DECL_LIMIT;
    end else if (cfg.declination < -mshd_pkg::DECL_LIMIT) begin
      item.decl = -mshd_pkg::DECL_LIMIT;
    end else begin
      item.decl = cfg.declination;
    end
  end

endmodule

/* src/mshd_queue.sv */
// Short queue of prepared samples between the front end and the pipeline.
`timescale 1ns / 1ps
module mshd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  mshd_pkg::front_t wdata,
  output logic             full,
  input  logic             rd,
  output mshd_pkg::front_t rdata,
  output logic             empty
);

  localparam int AW = $clog2(mshd_pkg::QUEUE_DEPTH);

  mshd_pkg::front_t mem [mshd_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0] count;

  assign full = (count == (AW+1)'(mshd_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (AW+1)'(wr && !full) - (AW+1)'(rd && !empty);
    end
  end

endmodule

/* src/mshd_back.sv */
// Back end: scaling and CORDIC pipeline with the result queue.
`timescale 1ns / 1ps
module mshd_back (
  input  logic              clk,
  input  logic              rst,
  input  mshd_pkg::front_t  qdata,
  input  logic              qempty,
  output logic              qpop,
  output mshd_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);

  localparam int N = mshd_pkg::CORDIC_ITERATIONS;
  localparam int OW = $clog2(mshd_pkg::OUT_DEPTH);

  mshd_pkg::stage_t st [N+1];
  mshd_pkg::stage_t nxt [N+1];
  logic [N:0] vld;
  logic adv;

  mshd_pkg::result_t omem [mshd_pkg::OUT_DEPTH];
  logic [OW-1:0] owp, orp;
  logic [OW:0] ocount;
  logic ofull;
  mshd_pkg::result_t fin;
  logic signed [26:0] zw, zr;
  logic signed [15:0] ang;
  logic signed [16:0] hsum, hwrap;

  assign ofull = (ocount == (OW+1)'(mshd_pkg::OUT_DEPTH));
  assign adv = !vld[N] || !ofull;
  assign qpop = adv && !qempty;

  always_comb begin
    nxt[0] = '0;
    nxt[0].f = qdata;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= nxt[0];
    end
  end

  genvar k;
  generate
    for (k = 0; k < N; k++) begin : g_stage
      logic signed [26:0] xs, ys;
      logic [28:0] ql_x, ql_y, ql_z;
      logic [17:0] q_x, q_y, q_z;

      assign xs = st[k].f.cx >>> k;
      assign ys = st[k].f.cy >>> k;
      assign ql_x = {11'b0, st[k].qe_x} * {18'b0, st[k].f.lsb_xy};
      assign ql_y = {11'b0, st[k].qe_y} * {18'b0, st[k].f.lsb_xy};
      assign ql_z = {11'b0, st[k].qe_z} * {18'b0, st[k].f.lsb_z};
      assign q_x = st[k].qe_x + 18'(st[k].rem_x >= {15'b0, st[k].f.lsb_xy});
      assign q_y = st[k].qe_y + 18'(st[k].rem_y >= {15'b0, st[k].f.lsb_xy});
      assign q_z = st[k].qe_z + 18'(st[k].rem_z >= {15'b0, st[k].f.lsb_z});

      always_comb begin
        nxt[k+1] = st[k];
        if (st[k].f.cy >= 27'sd0) begin
          nxt[k+1].f.cx = st[k].f.cx + ys;
          nxt[k+1].f.cy = st[k].f.cy - xs;
          nxt[k+1].f.cz = st[k].f.cz + $signed({5'b0, mshd_pkg::ATAN_TAB[k]});
        end else begin
          nxt[k+1].f.cx = st[k].f.cx - ys;
          nxt[k+1].f.cy = st[k].f.cy + xs;
          nxt[k+1].f.cz = st[k].f.cz - $signed({5'b0, mshd_pkg::ATAN_TAB[k]});
        end
        if (k == 0) begin
          nxt[k+1].prod_x = 50'({24'b0, st[k].f.mag_x} * {25'b0, st[k].f.rcp_xy});
          nxt[k+1].prod_y = 50'({24'b0, st[k].f.mag_y} * {25'b0, st[k].f.rcp_xy});
          nxt[k+1].prod_z = 50'({24'b0, st[k].f.mag_z} * {25'b0, st[k].f.rcp_z});
        end
        if (k == 1) begin
          nxt[k+1].qe_x = st[k].prod_x[49:32];
          nxt[k+1].qe_y = st[k].prod_y[49:32];
          nxt[k+1].qe_z = st[k].prod_z[49:32];
        end
        if (k == 2) begin
          nxt[k+1].rem_x = st[k].f.mag_x - ql_x[25:0];
          nxt[k+1].rem_y = st[k].f.mag_y - ql_y[25:0];
          nxt[k+1].rem_z = st[k].f.mag_z - ql_z[25:0];
        end
        if (k == 3) begin
          nxt[k+1].fld_x = st[k].f.neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
          nxt[k+1].fld_y = st[k].f.neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});
          nxt[k+1].fld_z = st[k].f.neg_z ? -$signed({1'b0, q_z}) : $signed({1'b0, q_z});
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          st[k+1] <= nxt[k+1];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N-1:0], !qempty};
    end
  end

  always_comb begin
    zw = (st[N].f.cz > mshd_pkg::Z_HALF) ? st[N].f.cz - mshd_pkg::Z_FULL : st[N].f.cz;
    zr = (zw + mshd_pkg::Z_ROUND) >>> 10;
    ang = st[N].f.on_axis ? st[N].f.axis_angle : zr[15:0];
    hsum = 17'(ang) + 17'(st[N].f.decl);
    if (hsum < 17'sd0) begin
      hwrap = hsum + mshd_pkg::HEADING_FULL;
    end else if (hsum > mshd_pkg::HEADING_FULL) begin
      hwrap = hsum - mshd_pkg::HEADING_FULL;
    end else begin
      hwrap = hsum;
    end
    fin.field_x = st[N].fld_x;
    fin.field_y = st[N].fld_y;
    fin.field_z = st[N].fld_z;
    fin.heading = hwrap[14:0];
  end

  assign empty = (ocount == '0);
  assign result = omem[orp];

  always_ff @(posedge clk) begin
    if (vld[N] && !ofull) begin
      omem[owp] <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0;
      orp <= '0;
      ocount <= '0;
    end else begin
      if (vld[N] && !ofull) begin
        owp <= owp + 1'b1;
      end
      if (pop && !empty) begin
        orp <= orp + 1'b1;
      end
      ocount <= ocount + (OW+1)'(vld[N] && !ofull) - (OW+1)'(pop && !empty);
    end
  end

`ifndef SYNTHESIS
  a_ocount_bound: assert property (@(posedge clk) disable iff (rst)
    ocount <= (OW+1)'(mshd_pkg::OUT_DEPTH))
    else $error("result queue overfilled");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vld[N] && ofull) |=> vld[N] && $stable(st[N]))
    else $error("last stage lost while stalled");
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.heading <= 15'd23040)
    else $error("heading out of range");
`endif

endmodule

/* src/magnetometer_scale_and_heading_top.sv */
// Top level: register port, front end, sample queue and pipeline of the heading block.
//
//  channel   handshake          payload
//  input     push / full        x_high x_low z_high z_low y_high y_low
//  result    empty / pop        field_x field_y field_z heading
//  config    psel penable ...   gain_select (0x0), declination (0x4)
//
// One sample is taken per cycle while full is low; results pass through the input
// queue, the one-step-per-stage CORDIC pipeline and the result queue.
// Reset clears the queues and the pipeline valid bits and sets the registers to their reset values.
// A stalled result side fills the result queue, then the pipeline holds and
// the input queue fills before full rises.
`timescale 1ns / 1ps
module magnetometer_scale_and_heading_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         x_high,
  input  logic [7:0]         x_low,
  input  logic [7:0]         z_high,
  input  logic [7:0]         z_low,
  input  logic [7:0]         y_high,
  input  logic [7:0]         y_low,
  output logic               empty,
  input  logic               pop,
  output logic signed [18:0] field_x,
  output logic signed [18:0] field_y,
  output logic signed [18:0] field_z,
  output logic [14:0]        heading
);

  mshd_pkg::cfg_t cfg;
  mshd_pkg::front_t fitem, qitem;
  mshd_pkg::result_t res;
  logic qempty, qpop, wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_select <= 3'd0;
      cfg.declination <= $signed(mshd_pkg::DECL_RESET);
    end else if (wr_en) begin
      case (paddr[2])
        mshd_pkg::REG_GAIN_SELECT: begin
          if (pwdata[2:0] != mshd_pkg::GAIN_INVALID) begin
            cfg.gain_select <= pwdata[2:0];
          end
        end
        mshd_pkg::REG_DECLINATION: begin
          cfg.declination <= $signed(pwdata[14:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mshd_pkg::REG_GAIN_SELECT: prdata = {29'b0, cfg.gain_select};
      mshd_pkg::REG_DECLINATION: prdata = {17'b0, cfg.declination};
      default: prdata = '0;
    endcase
  end

  mshd_front u_front (
    .x_high(x_high), .x_low(x_low), .z_high(z_high), .z_low(z_low),
    .y_high(y_high), .y_low(y_low), .cfg(cfg), .item(fitem)
  );

  mshd_queue u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(fitem), .full(full),
    .rd(qpop), .rdata(qitem), .empty(qempty)
  );

  mshd_back u_back (
    .clk(clk), .rst(rst), .qdata(qitem), .qempty(qempty), .qpop(qpop),
    .result(res), .empty(empty), .pop(pop)
  );

  assign field_x = res.field_x;
  assign field_y = res.field_y;
  assign field_z = res.field_z;
  assign heading = res.heading;

endmodule
